>>> design/stq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer expiry queue.
// ---------------------------------------------------------------------------
package stq_pkg;
   localparam int ENTRIES   = 16;
   localparam int TIME_BITS = 48;
   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_WATCH  = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [1:0] KIND_WATCH  = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_EXPIRE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] timer_id;
      logic [23:0] timeout;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] result_id;
      logic [1:0]  status;
      logic        last;
   } rsp_type;
endpackage

>>> design/sorted_timer_expiry_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_timer_expiry_queue
// Sorted timer list in one synchronous memory, walked one entry at a time.
// ---------------------------------------------------------------------------
// channel | dir | payload  | handshake
// req     | in  | req_type | req_valid / req_ready
// rsp     | out | rsp_type | rsp_valid / rsp_ready
// Each command walks the list through one memory port, one entry at a time.
// Cancel: search, shift out. Watch: search, shift out, find slot, insert shift.
// Tick: advance time, then shift out and report each expired head entry.
// Synchronous reset clears time and count; memory contents need no clear.
// One request is in work at a time; rsp stalls hold the walk and req_ready.
module sorted_timer_expiry_queue
   import stq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   typedef struct packed {
      logic [15:0]          id;
      logic [TIME_BITS-1:0] exp;
   } ent_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND_RD, S_FIND_CHK, S_DEL_RD, S_DEL_WR,
      S_INS_CHK, S_INS_RD, S_INS_WR, S_TICK_RD, S_TICK_CHK, S_RESP
   } state_type;

   ent_type mem [ENTRIES];
   ent_type rd_ff;
   logic [IDX_BITS-1:0] raddr;
   logic                we;
   logic [IDX_BITS-1:0] waddr;
   ent_type             wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   state_type            state_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [CNT_BITS-1:0]  cnt_ff, pos_ff, ins_ff;
   req_type              req_ff;
   logic [TIME_BITS-1:0] exp_ff;
   logic                 found_ff, tickany_ff;
   logic                 rv_ff;
   rsp_type              rsp_ff;
   ent_type              held_ff;
   logic                 rsp_load;

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   assign rsp_load = (!rv_ff || rsp_ready) &&
      ((state_ff == S_RESP) ||
       (state_ff == S_TICK_CHK && req_ff.opcode != OP_WATCH && tickany_ff &&
        rd_ff.exp <= now_ff));

   always_comb begin
      raddr = pos_ff[IDX_BITS-1:0];
      we    = 1'b0;
      waddr = pos_ff[IDX_BITS-1:0];
      wdata = rd_ff;
      if (state_ff == S_DEL_RD) raddr = IDX_BITS'(pos_ff + 1'b1);
      if (state_ff == S_INS_RD) raddr = IDX_BITS'(pos_ff - 1'b1);
      if (state_ff == S_DEL_WR) begin
         we = 1'b1;
      end
      if (state_ff == S_INS_WR) begin
         we = 1'b1;
         if (pos_ff == ins_ff) wdata = '{id: req_ff.timer_id, exp: exp_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         now_ff   <= '0;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready && !rsp_load) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && !rv_ff) begin
               req_ff   <= req_data;
               exp_ff   <= now_ff + TIME_BITS'(req_data.timeout);
               pos_ff   <= '0;
               found_ff <= 1'b0;
               tickany_ff <= 1'b0;
               case (req_data.opcode) inside
                  OP_TICK: begin
                     now_ff   <= now_ff + 1'b1;
                     state_ff <= S_TICK_RD;
                  end
                  OP_WATCH, OP_CANCEL: state_ff <= S_FIND_RD;
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_FIND_RD:
               if (pos_ff == cnt_ff) begin
                  if (req_ff.opcode == OP_WATCH) begin
                     pos_ff   <= '0;
                     state_ff <= S_INS_CHK;
                  end else state_ff <= S_RESP;
               end else state_ff <= S_FIND_CHK;
            S_FIND_CHK:
               if (rd_ff.id == req_ff.timer_id) begin
                  found_ff <= 1'b1;
                  state_ff <= S_DEL_RD;
               end else begin
                  pos_ff   <= pos_ff + 1'b1;
                  state_ff <= S_FIND_RD;
               end
            S_DEL_RD:
               if (CNT_BITS'(pos_ff + 1'b1) >= cnt_ff) begin
                  cnt_ff <= cnt_ff - 1'b1;
                  if (req_ff.opcode == OP_WATCH) begin
                     pos_ff   <= '0;
                     state_ff <= S_INS_CHK;
                  end else if (req_ff.opcode == OP_TICK) begin
                     pos_ff   <= '0;
                     state_ff <= S_TICK_RD;
                  end else state_ff <= S_RESP;
               end else state_ff <= S_DEL_WR;
            S_DEL_WR: begin
               pos_ff   <= pos_ff + 1'b1;
               state_ff <= S_DEL_RD;
            end
            S_INS_CHK:
               if (cnt_ff == CNT_BITS'(ENTRIES)) state_ff <= S_RESP;
               else if (pos_ff == cnt_ff) begin
                  ins_ff   <= pos_ff;
                  pos_ff   <= cnt_ff;
                  state_ff <= S_INS_RD;
               end else state_ff <= S_TICK_CHK;
            S_INS_RD:
               state_ff <= S_INS_WR;
            S_INS_WR:
               if (pos_ff == ins_ff) begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_RESP;
               end else begin
                  pos_ff   <= pos_ff - 1'b1;
                  state_ff <= S_INS_RD;
               end
            S_TICK_RD:
               if (req_ff.opcode == OP_WATCH) state_ff <= S_TICK_CHK;
               else if (cnt_ff == '0) state_ff <= tickany_ff ? S_RESP : S_IDLE;
               else state_ff <= S_TICK_CHK;
            S_TICK_CHK:
               if (req_ff.opcode == OP_WATCH) begin
                  if (rd_ff.exp <= exp_ff) begin
                     pos_ff   <= pos_ff + 1'b1;
                     state_ff <= S_INS_CHK;
                  end else begin
                     ins_ff   <= pos_ff;
                     pos_ff   <= cnt_ff;
                     state_ff <= S_INS_RD;
                  end
               end else if (rd_ff.exp <= now_ff) begin
                  if (tickany_ff) begin
                     if (!rv_ff || rsp_ready) begin
                        rv_ff    <= 1'b1;
                        rsp_ff   <= '{KIND_EXPIRE, held_ff.id, ST_OK, 1'b0};
                        held_ff  <= rd_ff;
                        state_ff <= S_DEL_RD;
                     end
                  end else begin
                     tickany_ff <= 1'b1;
                     held_ff    <= rd_ff;
                     state_ff   <= S_DEL_RD;
                  end
               end else state_ff <= tickany_ff ? S_RESP : S_IDLE;
            S_RESP:
               if (!rv_ff || rsp_ready) begin
                  rv_ff <= 1'b1;
                  state_ff <= S_IDLE;
                  case (req_ff.opcode)
                     OP_TICK:  rsp_ff <= '{KIND_EXPIRE, held_ff.id, ST_OK, 1'b1};
                     OP_WATCH: rsp_ff <= '{KIND_WATCH, req_ff.timer_id,
                        (cnt_ff == CNT_BITS'(ENTRIES) && state_ff == S_RESP &&
                         pos_ff != ins_ff) ? ST_FULL : ST_OK, 1'b1};
                     default:  rsp_ff <= '{KIND_CANCEL, req_ff.timer_id,
                        found_ff ? ST_OK : ST_NOTFOUND, 1'b1};
                  endcase
               end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_IDLE && req_valid && !rv_ff) ins_ff <= '1;
      end
   end
endmodule

>>> design/stq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stq_checker
// Port-level checks for the sorted timer expiry queue.
// ---------------------------------------------------------------------------
module stq_checker
   import stq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while a response is waiting");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_EXPIRE |-> rsp_data.last)
      else $error("watch/cancel answer without last");
   a_expire_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_EXPIRE |-> rsp_data.status == ST_OK)
      else $error("expire with bad status");
endmodule

bind sorted_timer_expiry_queue stq_checker u_stq_checker (.*);

>>> test/stq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stq_scoreboard
// Watches both channels, keeps a model of the timer list and compares each
// response with the one predicted from the accepted requests.
// ---------------------------------------------------------------------------
module stq_scoreboard
   import stq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      rsp_count,
   output int      expire_count,
   output int      full_count
);
   logic [TIME_BITS-1:0] now_ticks;
   logic [15:0]          list_id [ENTRIES];
   logic [TIME_BITS-1:0] list_exp [ENTRIES];
   int                   list_len;
   rsp_type              rsp_due [$];

   function automatic void add_due(rsp_type r);
      rsp_due.insert(rsp_due.size(), r);
   endfunction

   function automatic void drop_slot(int pos);
      for (int i = pos; i < list_len - 1; i++) begin
         list_id[i]  = list_id[i+1];
         list_exp[i] = list_exp[i+1];
      end
      list_len--;
   endfunction

   function automatic bit drop_timer(logic [15:0] id);
      for (int i = 0; i < list_len; i++) begin
         if (list_id[i] == id) begin
            drop_slot(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void predict_timer_op(req_type rq);
      rsp_type              r;
      logic [TIME_BITS-1:0] exp_at;
      int                   pos;
      int                   first;
      case (rq.opcode)
         OP_TICK: begin
            now_ticks = now_ticks + 1'b1;
            first = rsp_due.size();
            while (list_len > 0 && list_exp[0] <= now_ticks) begin
               r = '{KIND_EXPIRE, list_id[0], ST_OK, 1'b0};
               add_due(r);
               drop_slot(0);
            end
            if (rsp_due.size() > first) rsp_due[rsp_due.size()-1].last = 1'b1;
         end
         OP_WATCH: begin
            exp_at = now_ticks + TIME_BITS'(rq.timeout);
            void'(drop_timer(rq.timer_id));
            if (list_len >= ENTRIES) begin
               r = '{KIND_WATCH, rq.timer_id, ST_FULL, 1'b1};
            end else begin
               pos = 0;
               while (pos < list_len && list_exp[pos] <= exp_at) pos++;
               for (int i = list_len; i > pos; i--) begin
                  list_id[i]  = list_id[i-1];
                  list_exp[i] = list_exp[i-1];
               end
               list_id[pos]  = rq.timer_id;
               list_exp[pos] = exp_at;
               list_len++;
               r = '{KIND_WATCH, rq.timer_id, ST_OK, 1'b1};
            end
            add_due(r);
         end
         OP_CANCEL: begin
            r = '{KIND_CANCEL, rq.timer_id,
                  drop_timer(rq.timer_id) ? ST_OK : ST_NOTFOUND, 1'b1};
            add_due(r);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         now_ticks = '0;
         list_len = 0;
         rsp_due.delete();
         fail_count <= 0;
         rsp_count <= 0;
         expire_count <= 0;
         full_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (rsp_data.kind == KIND_EXPIRE) expire_count <= expire_count + 1;
            if (rsp_data.status == ST_FULL) full_count <= full_count + 1;
            if (rsp_due.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %p",
                        $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_due.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_timer_op(req_data);
      end
      pending = rsp_due.size();
   end
endmodule

>>> test/sorted_timer_expiry_queue_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_timer_expiry_queue_tb
// Drives tick, watch, cancel and unused-opcode requests with random gaps and
// response stalls; the checker predicts every response and counts mismatches.
// ---------------------------------------------------------------------------
module sorted_timer_expiry_queue_tb;
   import stq_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count, pending, rsp_count, expire_count, full_count;
   bit      calm;
   int      sent;

   sorted_timer_expiry_queue u_top (.*);

   stq_scoreboard u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_request(logic [1:0] op, logic [15:0] id, logic [23:0] tmo);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op, id, tmo};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   initial begin
      logic [1:0]  op;
      logic [15:0] id;
      int          pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      calm = 1'b0;
      sent = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      send_request(OP_TICK, 16'h0000, 24'h0);
      send_request(OP_CANCEL, 16'hFFFF, 24'h0);
      send_request(OP_WATCH, 16'hFFFF, 24'hFFFFFF);
      send_request(OP_WATCH, 16'h0000, 24'h0);
      send_request(OP_WATCH, 16'h0001, 24'h2);
      send_request(OP_WATCH, 16'h0002, 24'h2);
      send_request(OP_WATCH, 16'h0001, 24'h3);
      send_request(2'd3, 16'hAAAA, 24'h555555);
      send_request(OP_TICK, 16'h5555, 24'hAAAAAA);
      send_request(OP_TICK, 16'h0, 24'h0);
      send_request(OP_TICK, 16'h0, 24'h0);
      send_request(OP_CANCEL, 16'hFFFF, 24'h0);
      for (int i = 0; i < 17; i++) send_request(OP_WATCH, 16'(16 + i), 24'd5);
      req_valid <= 1'b0;
      wait (pending == 0);
      for (int i = 0; i < 5; i++) send_request(OP_TICK, 16'h0, 24'h0);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (80) @(negedge clock);

      for (int n = 0; n < 230; n++) begin
         if (n == 190) calm = 1'b1;
         pick = $urandom_range(0, 99);
         id = (pick < 90) ? 16'($urandom_range(0, 23)) : 16'($urandom);
         if (pick < 40) op = OP_TICK;
         else if (pick < 75) op = OP_WATCH;
         else if (pick < 97) op = OP_CANCEL;
         else op = 2'd3;
         send_request(op, id, ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                           : 24'($urandom_range(0, 12)));
      end
      // drain: let the short timers expire
      for (int i = 0; i < 20; i++) send_request(OP_TICK, 16'h0, 24'h0);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (80) @(negedge clock);
      $display("Sent %0d requests, got %0d responses (%0d expiries, %0d full rejects).",
               sent, rsp_count, expire_count, full_count);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
